// ===== rtl/bcdrtc_pkg.sv =====
// Package for the BCD RTC snapshot to epoch-seconds converter.
// Holds payload structs, register masks, config register indexes and decode helpers.
// No dependencies.
package bcdrtc_pkg;

  localparam int EPOCH_W = 33;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 4;

  // Config register index, taken from paddr[3] (registers sit at 8-byte pitch)
  typedef enum logic {
    REG_PLAUSIBLE_FLOOR = 1'b0,
    REG_UNUSED          = 1'b1
  } cfg_reg_t;

  localparam logic [EPOCH_W-1:0] FLOOR_RESET = 33'd946684800;

  localparam logic [7:0] SEC_MASK    = 8'h7F;
  localparam logic [7:0] MIN_MASK    = 8'h7F;
  localparam logic [7:0] HR_MODE12   = 8'h40;
  localparam logic [7:0] HR_PM       = 8'h20;
  localparam logic [7:0] HR12_MASK   = 8'h1F;
  localparam logic [7:0] HR24_MASK   = 8'h3F;
  localparam logic [7:0] DATE_MASK   = 8'h3F;
  localparam logic [7:0] MONTH_MASK  = 8'h1F;
  localparam logic [7:0] CENTURY_BIT = 8'h80;

  // Days from 1970-01-01 relative to the shifted-year day count (see top level)
  localparam logic [18:0] DAY_OFFSET  = 19'd135080;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  typedef struct packed {
    logic [7:0] seconds_reg;
    logic [7:0] minutes_reg;
    logic [7:0] hours_reg;
    logic [7:0] date_reg;
    logic [7:0] month_century_reg;
    logic [7:0] year_reg;
  } rtc_snapshot_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_seconds;
    logic               valid_res;
  } epoch_result_t;

  function automatic logic bcd_ok(input logic [7:0] v);
    return (v[7:4] <= 4'd9) && (v[3:0] <= 4'd9);
  endfunction

  function automatic logic [6:0] bcd_value(input logic [7:0] v);
    return 7'(v[7:4]) * 7'd10 + 7'(v[3:0]);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    unique case (month)
      4'd2:                         d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      d = 5'd30;
      default:                      d = 5'd31;
    endcase
    return d;
  endfunction

  // Days before the start of shifted month mp (March = 0)
  function automatic logic [8:0] cum_days(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/bcd_rtc_regs_to_epoch_unit.sv =====
// Top level: BCD RTC register snapshot to seconds since 1970, four-stage pipeline.
// Depends on bcdrtc_pkg (payload structs, masks, decode tables).
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------------
//  snapshot  | start, busy, snapshot                   | taken when start & !busy
//  result    | done, result                            | done strobe, one cycle, no stall
//  config    | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// One item per cycle; the result passes four registered stages after acceptance (decode,
// day count, scale by 86400, floor compare). busy is high only during reset.
// Synchronous reset clears the stage valid bits and sets the floor to 946684800.
// The result side cannot stall, so the pipeline never holds.
module bcd_rtc_regs_to_epoch_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bcdrtc_pkg::rtc_snapshot_t     snapshot,
  output logic                          done,
  output bcdrtc_pkg::epoch_result_t     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcdrtc_pkg::APB_AW-1:0] paddr,
  input  logic [bcdrtc_pkg::APB_DW-1:0] pwdata,
  output logic [bcdrtc_pkg::APB_DW-1:0] prdata,
  output logic                          pready
);
  import bcdrtc_pkg::*;

  // ---------------- config ----------------
  logic [EPOCH_W-1:0] plausible_floor;
  cfg_reg_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      plausible_floor <= FLOOR_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel == REG_PLAUSIBLE_FLOOR) begin
      plausible_floor <= pwdata[EPOCH_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PLAUSIBLE_FLOOR: prdata = APB_DW'(plausible_floor);
      default:             prdata = '0;
    endcase
  end

  assign busy = rst;

  // ---------------- stage 1: BCD decode and field checks ----------------
  logic       accept;
  logic [7:0] sec_m, min_m, hr12_m, hr24_m, date_m, mon_m;
  logic [6:0] sec_v, min_v, hr12_v, hr24_v, date_v, mon_v, year_v;
  logic       hr_mode12, hr_pm;
  logic       ok_hour;
  logic [4:0] hour_dec;
  logic [7:0] year_off;
  logic       leap;
  logic       ok_all;

  assign accept = start && !busy;

  always_comb begin
    sec_m  = snapshot.seconds_reg & SEC_MASK;
    min_m  = snapshot.minutes_reg & MIN_MASK;
    hr12_m = snapshot.hours_reg & HR12_MASK;
    hr24_m = snapshot.hours_reg & HR24_MASK;
    date_m = snapshot.date_reg & DATE_MASK;
    mon_m  = snapshot.month_century_reg & MONTH_MASK;

    sec_v  = bcd_value(sec_m);
    min_v  = bcd_value(min_m);
    hr12_v = bcd_value(hr12_m);
    hr24_v = bcd_value(hr24_m);
    date_v = bcd_value(date_m);
    mon_v  = bcd_value(mon_m);
    year_v = bcd_value(snapshot.year_reg);

    hr_mode12 = (snapshot.hours_reg & HR_MODE12) != 8'h00;
    hr_pm     = (snapshot.hours_reg & HR_PM) != 8'h00;

    if (hr_mode12) begin
      ok_hour  = bcd_ok(hr12_m) && hr12_v >= 7'd1 && hr12_v <= 7'd12;
      // twelve o'clock counts as zero before the PM offset
      hour_dec = (hr12_v == 7'd12) ? 5'd0 : hr12_v[4:0];
      if (hr_pm) begin
        hour_dec = hour_dec + 5'd12;
      end
    end else begin
      ok_hour  = bcd_ok(hr24_m) && hr24_v <= 7'd23;
      hour_dec = hr24_v[4:0];
    end

    year_off = 8'(year_v) +
               (((snapshot.month_century_reg & CENTURY_BIT) != 8'h00) ? 8'd100 : 8'd0);
    // 2000..2199: leap when divisible by 4, except 2100
    leap = (year_off[1:0] == 2'b00) && (year_off != 8'd100);

    ok_all = bcd_ok(sec_m) && bcd_ok(min_m) && ok_hour && bcd_ok(date_m) &&
             bcd_ok(mon_m) && bcd_ok(snapshot.year_reg) &&
             sec_v <= 7'd59 && min_v <= 7'd59 &&
             mon_v >= 7'd1 && mon_v <= 7'd12 && date_v >= 7'd1 &&
             date_v <= 7'(month_days(mon_v[3:0], leap));
  end

  logic       s1_valid, s1_ok;
  logic [5:0] s1_sec, s1_min;
  logic [4:0] s1_hour, s1_date;
  logic [3:0] s1_month;
  logic [7:0] s1_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok    <= ok_all;
    s1_sec   <= sec_v[5:0];
    s1_min   <= min_v[5:0];
    s1_hour  <= hour_dec;
    s1_date  <= date_v[4:0];
    s1_month <= mon_v[3:0];
    s1_year  <= year_off;
  end

  // ---------------- stage 2: day count and time of day ----------------
  // Years counted from 1600 with March as first month: k in 399..599.
  logic        jan_feb;
  logic [3:0]  mp;
  logic [9:0]  k;
  logic [2:0]  k_div100;
  logic        k_div400;
  logic [18:0] doe;
  logic [16:0] hms;

  always_comb begin
    jan_feb  = s1_month <= 4'd2;
    mp       = jan_feb ? s1_month + 4'd9 : s1_month - 4'd3;
    k        = 10'd400 + 10'(s1_year) - 10'(jan_feb);
    k_div100 = (k >= 10'd500) ? 3'd5 : (k >= 10'd400) ? 3'd4 : 3'd3;
    k_div400 = k >= 10'd400;
    doe      = 19'(k) * 19'd365 + 19'(k[9:2]) - 19'(k_div100) + 19'(k_div400) +
               19'(cum_days(mp)) + 19'(s1_date) - 19'd1;
    hms      = 17'(s1_hour) * 17'd3600 + 17'(s1_min) * 17'd60 + 17'(s1_sec);
  end

  logic        s2_valid, s2_ok;
  logic [16:0] s2_days, s2_hms;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ok   <= s1_ok;
    s2_days <= 17'(doe - DAY_OFFSET);
    s2_hms  <= hms;
  end

  // ---------------- stage 3: scale days to seconds ----------------
  logic               s3_valid, s3_ok;
  logic [EPOCH_W-1:0] s3_time;
  logic [EPOCH_W-1:0] day_secs;

  assign day_secs = EPOCH_W'(s2_days) * EPOCH_W'(SEC_PER_DAY) + EPOCH_W'(s2_hms);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_ok   <= s2_ok;
    s3_time <= day_secs;
  end

  // ---------------- stage 4: floor check and output register ----------------
  logic               res_valid;
  logic [EPOCH_W-1:0] res_epoch;
  logic               pass;

  assign pass = s3_ok && (s3_time >= plausible_floor);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_valid <= pass;
    res_epoch <= pass ? s3_time : '0;
  end

  assign result.epoch_seconds = res_epoch;
  assign result.valid_res     = res_valid;

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("accepted item did not complete in four cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching accepted item");

  a_floor: assert property (@(posedge clk) disable iff (rst)
    done && result.valid_res |-> result.epoch_seconds >= plausible_floor)
    else $error("valid result below plausibility floor");

  a_zero_reject: assert property (@(posedge clk) disable iff (rst)
    done && !result.valid_res |-> result.epoch_seconds == '0)
    else $error("rejected item carries nonzero time");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for bcd_rtc_regs_to_epoch_unit: BCD clock snapshots in, epoch seconds out.
// Depends on bcdrtc_pkg and the top level; predicts each result and checks it in order.
module tb;
  import bcdrtc_pkg::*;

  localparam int PIPE_LAT = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 157;
  localparam longint unsigned MAX_EPOCH = 64'd7258118399;

  typedef enum int {MIX_CLEAN, MIX_BROKEN, MIX_NOISE} snap_mix_t;
  typedef enum int {
    FAULT_SECONDS, FAULT_MINUTES, FAULT_HOUR24, FAULT_HOUR12, FAULT_DATE_PAST_END,
    FAULT_FEB29, FAULT_MONTH, FAULT_DATE_ZERO, FAULT_NIBBLE
  } fault_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  rtc_snapshot_t       snapshot;
  logic                done;
  epoch_result_t       result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  epoch_result_t       expected_epochs[$];
  logic [EPOCH_W-1:0]  floor_shadow = FLOOR_RESET;
  int                  mismatch_count = 0;
  int                  items_sent = 0;
  int                  floor_writes = 0;
  int                  n_valid = 0;
  int                  n_rejected = 0;
  int                  idle_cycles = 0;
  int                  burst_left = 0;

  bcd_rtc_regs_to_epoch_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .snapshot (snapshot),
    .done     (done),
    .result   (result),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  function automatic bit bcd_to_bin(input logic [7:0] v, output int unsigned n);
    n = 0;
    if (v[7:4] > 4'd9 || v[3:0] > 4'd9) return 1'b0;
    n = v[7:4] * 10 + v[3:0];
    return 1'b1;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    bit leap;
    leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Day count from a March-based year, good for 1999 onward
  function automatic longint unsigned days_since_1970(input int unsigned y,
                                                      input int unsigned m,
                                                      input int unsigned d);
    int unsigned yy, era, yoe, mp, doy, doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + doe - 719468;
  endfunction

  function automatic epoch_result_t predict_epoch(input rtc_snapshot_t s,
                                                  input logic [EPOCH_W-1:0] floor_val);
    epoch_result_t   r;
    int unsigned     sec, mins, hr, day, mon, yr, cal_year;
    logic [7:0]      h;
    bit              ok;
    longint unsigned t;
    r  = '0;
    ok = 1'b1;
    h  = s.hours_reg;
    if (!bcd_to_bin({1'b0, s.seconds_reg[6:0]}, sec)) ok = 1'b0;
    if (!bcd_to_bin({1'b0, s.minutes_reg[6:0]}, mins)) ok = 1'b0;
    if (h[6]) begin
      if (!bcd_to_bin({3'b000, h[4:0]}, hr)) ok = 1'b0;
      if (hr < 1 || hr > 12) ok = 1'b0;
      if (hr == 12) hr = 0;
      if (h[5]) hr += 12;
    end else begin
      if (!bcd_to_bin({2'b00, h[5:0]}, hr)) ok = 1'b0;
    end
    if (!bcd_to_bin({2'b00, s.date_reg[5:0]}, day)) ok = 1'b0;
    if (!bcd_to_bin({3'b000, s.month_century_reg[4:0]}, mon)) ok = 1'b0;
    if (!bcd_to_bin(s.year_reg, yr)) ok = 1'b0;
    if (hr > 23 || mins > 59 || sec > 59) ok = 1'b0;
    if (mon < 1 || mon > 12 || day < 1) ok = 1'b0;
    if (!ok) return r;
    cal_year = 2000 + yr + (s.month_century_reg[7] ? 100 : 0);
    if (day > month_length(cal_year, mon)) return r;
    t = days_since_1970(cal_year, mon, day) * 86400 + hr * 3600 + mins * 60 + sec;
    if (t < floor_val) return r;
    r.epoch_seconds = t[EPOCH_W-1:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus builders

  function automatic rtc_snapshot_t pack_snapshot(input int unsigned y, input int unsigned mo,
                                                  input int unsigned d, input int unsigned h,
                                                  input int unsigned mi, input int unsigned s,
                                                  input bit twelve);
    rtc_snapshot_t r;
    int unsigned   hh;
    r.seconds_reg = to_bcd(s);
    r.minutes_reg = to_bcd(mi);
    if (twelve) begin
      hh = h % 12;
      if (hh == 0) hh = 12;
      r.hours_reg = HR_MODE12 | (h >= 12 ? HR_PM : 8'h00) | to_bcd(hh);
    end else begin
      r.hours_reg = to_bcd(h);
    end
    r.date_reg          = to_bcd(d);
    r.month_century_reg = to_bcd(mo) | (y >= 2100 ? CENTURY_BIT : 8'h00);
    r.year_reg          = to_bcd(y % 100);
    return r;
  endfunction

  function automatic rtc_snapshot_t random_snapshot(input snap_mix_t mix);
    rtc_snapshot_t r;
    fault_t        fault;
    int unsigned   y, mo, d;
    logic [47:0]   noise, bits;
    logic [7:0]    hr12;
    logic [3:0]    nib;
    noise = {$urandom, 16'($urandom)};
    if (mix == MIX_NOISE) return rtc_snapshot_t'(noise);
    fault = fault_t'($urandom_range(0, int'(FAULT_NIBBLE)));
    y  = $urandom_range(2000, 2199);
    mo = $urandom_range(1, 12);
    if (mix == MIX_BROKEN && fault == FAULT_FEB29) begin
      mo = 2;
      d  = 29;
    end else begin
      d = $urandom_range(1, month_length(y, mo));
    end
    r = pack_snapshot(y, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59), noise[10]);
    // bits the decoder must ignore
    r.seconds_reg[7]          = noise[0];
    r.minutes_reg[7]          = noise[1];
    r.hours_reg[7]            = noise[2];
    r.date_reg[7:6]           = noise[4:3];
    r.month_century_reg[6:5]  = noise[6:5];
    if (mix != MIX_BROKEN) return r;
    case (fault)
      FAULT_SECONDS:
        r.seconds_reg = {r.seconds_reg[7], 7'(to_bcd($urandom_range(60, 79)))};
      FAULT_MINUTES:
        r.minutes_reg = {r.minutes_reg[7], 7'(to_bcd($urandom_range(60, 79)))};
      FAULT_HOUR24:
        r.hours_reg = {r.hours_reg[7], 1'b0, 6'(to_bcd($urandom_range(24, 39)))};
      FAULT_HOUR12: begin
        hr12 = noise[8] ? 8'h00 : to_bcd($urandom_range(13, 19));
        r.hours_reg = {r.hours_reg[7], 1'b1, noise[9], 5'(hr12)};
      end
      FAULT_DATE_PAST_END:
        r.date_reg = {r.date_reg[7:6],
                      6'(to_bcd($urandom_range(month_length(y, mo) + 1, 39)))};
      FAULT_MONTH:
        r.month_century_reg = {r.month_century_reg[7:5],
                               5'(noise[11] ? 8'h00 : to_bcd($urandom_range(13, 19)))};
      FAULT_DATE_ZERO:
        r.date_reg = {r.date_reg[7:6], 6'b000000};
      FAULT_NIBBLE: begin
        bits = r;
        nib  = 4'($urandom_range(10, 15));
        bits[8 * $urandom_range(0, 5) +: 4] = nib;
        if (noise[7]) bits[7:4] = nib;  // high digit of the year
        r = rtc_snapshot_t'(bits);
      end
      default: ;  // leap day already placed
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic send_snapshot(input rtc_snapshot_t s);
    start    <= 1'b1;
    snapshot <= s;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Bursts of random length, mostly separated by gaps of random length
  task automatic send_paced(input rtc_snapshot_t s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    send_snapshot(s);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PLAUSIBLE_FLOOR) begin
      floor_shadow = data[EPOCH_W-1:0];
      floor_writes++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_calendar_edges();
    rtc_snapshot_t s;
    send_paced(pack_snapshot(2000, 1, 1, 0, 0, 0, 0));       // exactly the reset floor
    send_paced(pack_snapshot(2199, 12, 31, 23, 59, 59, 0));
    send_paced('0);
    send_paced('1);
    send_paced(pack_snapshot(2000, 2, 29, 12, 0, 0, 0));
    send_paced(pack_snapshot(2100, 2, 29, 6, 30, 0, 0));     // century, not leap
    send_paced(pack_snapshot(2001, 2, 29, 6, 30, 0, 0));
    send_paced(pack_snapshot(2023, 4, 31, 8, 0, 0, 0));
    send_paced(pack_snapshot(2150, 3, 1, 0, 15, 0, 1));      // 12 AM
    send_paced(pack_snapshot(2050, 7, 4, 12, 0, 0, 1));      // 12 PM
    s = pack_snapshot(2050, 7, 4, 0, 0, 0, 0);
    s.hours_reg = HR_MODE12;                                 // 12h hour 00
    send_paced(s);
    s.hours_reg = HR_MODE12 | HR_PM | 8'h13;
    send_paced(s);
    send_paced(pack_snapshot(2050, 7, 4, 24, 0, 0, 0));
    send_paced(pack_snapshot(2050, 7, 4, 10, 60, 0, 0));
    send_paced(pack_snapshot(2050, 7, 4, 10, 0, 60, 0));
    send_paced(pack_snapshot(2050, 13, 4, 10, 0, 0, 0));
    s = pack_snapshot(2050, 7, 4, 10, 0, 0, 0);
    s.seconds_reg = 8'h1A;
    send_paced(s);
    s = pack_snapshot(2124, 2, 29, 23, 59, 59, 1);
    s.seconds_reg[7]         = 1'b1;
    s.minutes_reg[7]         = 1'b1;
    s.hours_reg[7]           = 1'b1;
    s.date_reg[7:6]          = 2'b11;
    s.month_century_reg[6:5] = 2'b11;
    send_paced(s);
  endtask

  task automatic test_floor_threshold();
    longint unsigned t_ref;
    t_ref = days_since_1970(2087, 6, 15) * 86400 + 13 * 3600 + 45 * 60 + 30;
    wait_idle();
    write_cfg(REG_PLAUSIBLE_FLOOR, {31'($urandom), 33'(t_ref)});
    send_paced(pack_snapshot(2087, 6, 15, 13, 45, 29, 0));
    send_paced(pack_snapshot(2087, 6, 15, 13, 45, 30, 1));
    send_paced(pack_snapshot(2087, 6, 15, 13, 45, 31, 0));
    // the second slot holds nothing; the floor must not move
    wait_idle();
    write_cfg(REG_UNUSED, 64'd0);
    send_paced(pack_snapshot(2087, 6, 15, 13, 45, 29, 1));
    wait_idle();
    write_cfg(REG_PLAUSIBLE_FLOOR, 64'd0);
    send_paced(pack_snapshot(2000, 1, 1, 0, 0, 0, 0));
    wait_idle();
    write_cfg(REG_PLAUSIBLE_FLOOR, MAX_EPOCH);
    send_paced(pack_snapshot(2199, 12, 31, 23, 59, 59, 0));
    send_paced(pack_snapshot(2199, 12, 31, 23, 59, 58, 1));
    wait_idle();
    write_cfg(REG_PLAUSIBLE_FLOOR, {31'h7FFFFFFF, 33'h1FFFFFFFF});
    send_paced(pack_snapshot(2199, 12, 31, 23, 59, 59, 0));
  endtask

  task automatic test_random_traffic(input int per_phase);
    logic [APB_DW-1:0] floors [7];
    snap_mix_t         mix;
    int                roll;
    epoch_result_t     pick;
    floors[0] = 64'(FLOOR_RESET);
    floors[1] = 64'd0;
    pick      = predict_epoch(random_snapshot(MIX_CLEAN), '0);
    floors[2] = 64'(pick.epoch_seconds);
    pick      = predict_epoch(random_snapshot(MIX_CLEAN), '0);
    floors[3] = 64'(pick.epoch_seconds);
    floors[4] = MAX_EPOCH;
    floors[5] = {$urandom, $urandom};
    floors[6] = 64'(FLOOR_RESET);
    foreach (floors[p]) begin
      wait_idle();
      write_cfg(REG_PLAUSIBLE_FLOOR, floors[p]);
      repeat (per_phase) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) mix = MIX_CLEAN;
        else if (roll < 85) mix = MIX_BROKEN;
        else mix = MIX_NOISE;
        send_paced(random_snapshot(mix));
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_check
    epoch_result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_epochs.size() == 0) begin
          report_mismatch($sformatf("result with none pending: epoch %0d valid %0b",
                                    result.epoch_seconds, result.valid_res));
        end else begin
          want = expected_epochs.pop_front();
          if (result.valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res got %0b, expected %0b",
                                      result.valid_res, want.valid_res));
          if (result.epoch_seconds !== want.epoch_seconds)
            report_mismatch($sformatf("epoch_seconds got %0d, expected %0d",
                                      result.epoch_seconds, want.epoch_seconds));
        end
        if (result.valid_res === 1'b1) n_valid++;
        else n_rejected++;
      end
      if (start && !busy) expected_epochs.push_back(predict_epoch(snapshot, floor_shadow));
    end
    idle_cycles <= ((start && !busy) || done) ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    snapshot = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_calendar_edges();
    test_floor_threshold();
    test_random_traffic(RANDOM_PER_PHASE);

    start <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("Converted %0d snapshots under %0d floor settings: %0d valid, %0d rejected",
             items_sent, floor_writes + 1, n_valid, n_rejected);
    $display("Covered leap days, 12/24h modes, bad BCD, range faults, floor edges, noise");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
